### sv/mert_pkg.sv
// Shared constants, types and the table index function for the MIDI event remap table.
// No dependencies; every other file of the block but mert_channels imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mert_pkg;

   localparam int CHANNEL_COUNT = 16;
   localparam int STATUS_GROUPS = 16;
   localparam int KEY_COUNT     = 128;

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int G_W  = (STATUS_GROUPS > 1) ? $clog2(STATUS_GROUPS) : 1;
   localparam int K_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   localparam int TABLE_DEPTH = CHANNEL_COUNT * STATUS_GROUPS * KEY_COUNT;
   localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Rule: new_channel (5), new_status (9), new_data_one (8); entry adds a valid bit on top.
   localparam int RULE_W  = 22;
   localparam int ENTRY_W = RULE_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [8:0] STATUS_NOTEOFF = 9'h080;
   localparam logic [8:0] STATUS_NOTEON  = 9'h090;
   localparam logic [8:0] STATUS_CONTROL = 9'h0B0;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_MAP    = 1'b1
   } action_type;

   // Inclusive index ranges that one insert covers.
   typedef struct packed {
      logic [CH_W-1:0] ch_lo;
      logic [CH_W-1:0] ch_hi;
      logic [G_W-1:0]  g_lo;
      logic [G_W-1:0]  g_hi;
      logic [K_W-1:0]  k_lo;
      logic [K_W-1:0]  k_hi;
   } box_type;

   // One classified transaction waiting for the back end.
   typedef struct packed {
      action_type          act;
      box_type             box;
      logic [RULE_W-1:0]   rule;
      logic                lookup_ok;
      logic [TABLE_AW-1:0] index;
      logic [4:0]          ev_channel;
      logic [8:0]          ev_status;
      logic [7:0]          ev_data_one;
      logic [6:0]          ev_data_two;
   } cmd_type;

   function automatic logic [TABLE_AW-1:0] table_index(input logic [CH_W-1:0] ch,
                                                        input logic [G_W-1:0]  grp,
                                                        input logic [K_W-1:0]  key);
      int flat;
      flat = (int'(ch) * STATUS_GROUPS + int'(grp)) * KEY_COUNT + int'(key);
      return flat[TABLE_AW-1:0];
   endfunction

endpackage

`default_nettype wire

### sv/mert_channels.sv
// Handshake channel interfaces for the MIDI event remap table: request and response.
// Payload widths follow the block's field list; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface mert_req_if;
   logic              valid;
   logic              ready;
   logic              action;
   logic signed [4:0] channel;
   logic signed [8:0] status;
   logic signed [7:0] data_one;
   logic [6:0]        data_two;
   logic signed [4:0] new_channel;
   logic signed [8:0] new_status;
   logic signed [7:0] new_data_one;

   modport source (output valid, action, channel, status, data_one, data_two,
                   new_channel, new_status, new_data_one, input ready);
   modport sink   (input valid, action, channel, status, data_one, data_two,
                   new_channel, new_status, new_data_one, output ready);
endinterface

interface mert_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] out_channel;
   logic [7:0] out_status;
   logic [6:0] out_data_one;
   logic [6:0] out_data_two;
   logic       hit;

   modport source (output valid, out_channel, out_status, out_data_one, out_data_two, hit,
                   input ready);
   modport sink   (input valid, out_channel, out_status, out_data_one, out_data_two, hit,
                   output ready);
endinterface

`default_nettype wire

### sv/midi_event_remap_table.sv
// MIDI event remap table, top level: front end, command queue and back end.
// Depends on mert_pkg, mert_channels, mert_front, mert_queue and mert_back.
//
// Usage:
//   req_bus carries one transaction per valid/ready handshake. action 0 inserts a rule
//   (channel, status, data_one may be -1 as wildcards), action 1 maps one event.
//   rsp_bus returns exactly one result per map transaction; inserts return nothing.
// Timing:
//   A map result passes through the queue slot, the registered memory read and the
//   output register before it shows valid, and maps stream at one per cycle while the
//   response side keeps up; the rate is set by the single read port of the remap memory.
//   An insert holds the back end for one read-check-fill per entry it covers (channels x
//   status groups x keys), then a drain state; a full wildcard rule covers 32768 entries.
//   Inserts with nothing to cover are dropped in the front end.
// Reset:
//   Synchronous, active high. Afterwards the back end clears all 32768 entries of the
//   memory one entry a cycle; req_bus.ready stays low for that whole pass.
// Back-pressure:
//   A stalled response holds in the output register; the back end then stops, the
//   two-deep queue fills and req_bus.ready drops. Nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module midi_event_remap_table (
   input  wire logic  clock,
   input  wire logic  reset,
   mert_req_if.sink   req_bus,
   mert_rsp_if.source rsp_bus
);
   import mert_pkg::*;

   // Front to queue.
   logic    push;
   cmd_type push_cmd;
   logic    q_full;

   // Queue to back.
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   // Hold off new requests during the clearing pass.
   logic    clear_busy;

   mert_front u_front (
      .req_bus    (req_bus),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   mert_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   mert_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .clear_busy (clear_busy),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

### sv/mert_front.sv
// Front end: accepts request transactions and classifies them into queue commands.
// Depends on mert_pkg and mert_req_if.
`timescale 1ns / 1ps
`default_nettype none

module mert_front (
   mert_req_if.sink          req_bus,
   input  wire logic         q_full,
   input  wire logic         clear_busy,
   output logic              push,
   output mert_pkg::cmd_type push_cmd
);
   import mert_pkg::*;

   logic keep;

   assign req_bus.ready = !q_full && !clear_busy;

   always_comb begin
      keep = 1'b1;
      push_cmd.act         = action_type'(req_bus.action);
      push_cmd.rule        = {req_bus.new_channel, req_bus.new_status, req_bus.new_data_one};
      push_cmd.ev_channel  = req_bus.channel;
      push_cmd.ev_status   = req_bus.status;
      push_cmd.ev_data_one = req_bus.data_one;
      push_cmd.ev_data_two = req_bus.data_two;
      push_cmd.lookup_ok   = (req_bus.channel >= 0) && (req_bus.channel < CHANNEL_COUNT)
                          && (req_bus.status >= 0) && (int'(req_bus.status[8:4]) < STATUS_GROUPS)
                          && (req_bus.data_one >= 0) && (req_bus.data_one < KEY_COUNT);
      push_cmd.index = table_index(req_bus.channel[CH_W-1:0], req_bus.status[4 +: G_W],
                                   req_bus.data_one[K_W-1:0]);

      // Channel range: wildcard covers all channels.
      push_cmd.box.ch_lo = '0;
      push_cmd.box.ch_hi = CH_W'(CHANNEL_COUNT - 1);
      if (req_bus.channel >= 0) begin
         push_cmd.box.ch_lo = req_bus.channel[CH_W-1:0];
         push_cmd.box.ch_hi = req_bus.channel[CH_W-1:0];
         if (req_bus.channel >= CHANNEL_COUNT) keep = 1'b0;
      end

      // Group range: note-on also fills the adjacent note-off group.
      push_cmd.box.g_lo = '0;
      push_cmd.box.g_hi = G_W'(STATUS_GROUPS - 1);
      if (req_bus.status >= 0) begin
         if (req_bus.status == STATUS_NOTEON) begin
            push_cmd.box.g_lo = G_W'(STATUS_NOTEOFF[8:4]);
            push_cmd.box.g_hi = (STATUS_GROUPS > int'(STATUS_NOTEON[8:4]))
                              ? G_W'(STATUS_NOTEON[8:4]) : G_W'(STATUS_NOTEOFF[8:4]);
            if (STATUS_GROUPS <= int'(STATUS_NOTEOFF[8:4])) keep = 1'b0;
         end else begin
            push_cmd.box.g_lo = req_bus.status[4 +: G_W];
            push_cmd.box.g_hi = req_bus.status[4 +: G_W];
            if (int'(req_bus.status[8:4]) >= STATUS_GROUPS) keep = 1'b0;
         end
      end

      // Key range: wildcard covers all keys.
      push_cmd.box.k_lo = '0;
      push_cmd.box.k_hi = K_W'(KEY_COUNT - 1);
      if (req_bus.data_one >= 0) begin
         push_cmd.box.k_lo = req_bus.data_one[K_W-1:0];
         push_cmd.box.k_hi = req_bus.data_one[K_W-1:0];
         if (req_bus.data_one >= KEY_COUNT) keep = 1'b0;
      end

      // Drop inserts that cover no entry at all.
      push = req_bus.valid && req_bus.ready && ((push_cmd.act == ACT_MAP) || keep);
   end

endmodule

`default_nettype wire

### sv/mert_queue.sv
// Short command queue between the front end and the back end of the remap table.
// Depends on mert_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mert_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mert_pkg::cmd_type push_cmd,
   output logic                   q_full,
   output logic                   head_valid,
   output mert_pkg::cmd_type      head_cmd,
   input  wire logic              pop
);
   import mert_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### sv/mert_back.sv
// Back end: owns the remap memory, clears it after reset, walks insert ranges,
// looks up map events and holds the response register. Depends on mert_pkg, mert_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module mert_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire mert_pkg::cmd_type head_cmd,
   output logic                   pop,
   output logic                   clear_busy,
   mert_rsp_if.source             rsp_bus
);
   import mert_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_LOOK
   } state_type;

   // Remap memory and its registered read port.
   logic [ENTRY_W-1:0]  map_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                mem_re;
   logic [TABLE_AW-1:0] mem_ra;
   logic                mem_we;
   logic [TABLE_AW-1:0] mem_wa;
   logic [ENTRY_W-1:0]  mem_wd;

   state_type           state_ff, state_in;
   logic [TABLE_AW-1:0] clr_addr_ff, clr_addr_in;
   box_type             box_ff, box_in;
   logic [RULE_W-1:0]   rule_ff, rule_in;
   logic [CH_W-1:0]     w_ch_ff, w_ch_in;
   logic [G_W-1:0]      w_g_ff, w_g_in;
   logic [K_W-1:0]      w_k_ff, w_k_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [TABLE_AW-1:0] wr_addr_ff, wr_addr_in;
   cmd_type             look_ff, look_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_channel_ff, rsp_channel_in;
   logic [7:0]          rsp_status_ff, rsp_status_in;
   logic [6:0]          rsp_data_one_ff, rsp_data_one_in;
   logic [6:0]          rsp_data_two_ff, rsp_data_two_in;
   logic                rsp_hit_ff, rsp_hit_in;

   logic                out_free;
   logic                issue_ok;
   logic                hit;
   logic [4:0]          rule_ch;
   logic [8:0]          rule_st;
   logic [7:0]          rule_d1;
   logic                k_last, g_last, c_last;
   logic [TABLE_AW-1:0] walk_addr;

   assign clear_busy = (state_ff == S_CLEAR);

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_channel  = rsp_channel_ff;
   assign rsp_bus.out_status   = rsp_status_ff;
   assign rsp_bus.out_data_one = rsp_data_one_ff;
   assign rsp_bus.out_data_two = rsp_data_two_ff;
   assign rsp_bus.hit          = rsp_hit_ff;

   assign rule_ch   = rd_data_ff[RULE_W-1 -: 5];
   assign rule_st   = rd_data_ff[16:8];
   assign rule_d1   = rd_data_ff[7:0];
   assign hit       = look_ff.lookup_ok && rd_data_ff[ENTRY_W-1];
   assign k_last    = (w_k_ff == box_ff.k_hi);
   assign g_last    = (w_g_ff == box_ff.g_hi);
   assign c_last    = (w_ch_ff == box_ff.ch_hi);
   assign walk_addr = table_index(w_ch_ff, w_g_ff, w_k_ff);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      box_in          = box_ff;
      rule_in         = rule_ff;
      w_ch_in         = w_ch_ff;
      w_g_in          = w_g_ff;
      w_k_in          = w_k_ff;
      wr_pend_in      = 1'b0;
      wr_addr_in      = wr_addr_ff;
      look_in         = look_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_channel_in  = rsp_channel_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_data_one_in = rsp_data_one_ff;
      rsp_data_two_in = rsp_data_two_ff;
      rsp_hit_in      = rsp_hit_ff;
      pop             = 1'b0;
      issue_ok        = 1'b0;
      mem_re          = 1'b0;
      mem_ra          = head_cmd.index;
      // Second half of an insert step: fill only if the entry read back empty.
      mem_we          = wr_pend_ff && !rd_data_ff[ENTRY_W-1];
      mem_wa          = wr_addr_ff;
      mem_wd          = {1'b1, rule_ff};

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == TABLE_AW'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            issue_ok = 1'b1;
         end
         S_WALK: begin
            mem_re     = 1'b1;
            mem_ra     = walk_addr;
            wr_pend_in = 1'b1;
            wr_addr_in = walk_addr;
            if (!k_last) begin
               w_k_in = w_k_ff + 1'b1;
            end else begin
               w_k_in = box_ff.k_lo;
               if (!g_last) begin
                  w_g_in = w_g_ff + 1'b1;
               end else begin
                  w_g_in = box_ff.g_lo;
                  w_ch_in = w_ch_ff + 1'b1;
               end
            end
            if (k_last && g_last && c_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // Let the last fill land before any new read.
            state_in = S_IDLE;
         end
         S_LOOK: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit;
               rsp_channel_in  = (hit && !rule_ch[4]) ? rule_ch[3:0] : look_ff.ev_channel[3:0];
               rsp_status_in   = (hit && !rule_st[8]) ? rule_st[7:0] : look_ff.ev_status[7:0];
               rsp_data_one_in = (hit && !rule_d1[7]) ? rule_d1[6:0]
                                                      : look_ff.ev_data_one[6:0];
               rsp_data_two_in = (hit && (rule_st == STATUS_CONTROL)
                                  && (look_ff.ev_status == STATUS_NOTEOFF))
                               ? 7'd0 : look_ff.ev_data_two;
               state_in        = S_IDLE;
               issue_ok        = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Take the next command from the queue.
      if (issue_ok && head_valid) begin
         pop = 1'b1;
         if (head_cmd.act == ACT_MAP) begin
            mem_re   = 1'b1;
            mem_ra   = head_cmd.index;
            look_in  = head_cmd;
            state_in = S_LOOK;
         end else begin
            box_in   = head_cmd.box;
            rule_in  = head_cmd.rule;
            w_ch_in  = head_cmd.box.ch_lo;
            w_g_in   = head_cmd.box.g_lo;
            w_k_in   = head_cmd.box.k_lo;
            state_in = S_WALK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= map_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      box_ff          <= box_in;
      rule_ff         <= rule_in;
      w_ch_ff         <= w_ch_in;
      w_g_ff          <= w_g_in;
      w_k_ff          <= w_k_in;
      wr_addr_ff      <= wr_addr_in;
      look_ff         <= look_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_data_one_ff <= rsp_data_one_in;
      rsp_data_two_ff <= rsp_data_two_in;
      rsp_hit_ff      <= rsp_hit_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire
